### rtl/pfrs_pkg.sv
// Package for the stereo polyphase resampler: shared types and fixed widths.
// Used by the controller, datapath and top level; no dependencies.
`default_nettype none
package pfrs_pkg;
	localparam int unsigned SampleW = 16;
	localparam int unsigned CoefW = 18;
	localparam int unsigned PhaseW = 29;
	localparam int unsigned IncW = 28;
	localparam int unsigned UfW = 7;
	localparam int unsigned TapW = 11;
	localparam int unsigned ResultCap = 64;
	localparam int unsigned AccW = 48;

	// register indexes
	localparam logic [1:0] RegUpsample = 2'd0;
	localparam logic [1:0] RegIncrement = 2'd1;
	localparam logic [1:0] RegTapCount = 2'd2;

	// controller to datapath
	typedef struct packed {
		logic clear_acc;
		logic mac_en;
		logic push;
		logic set_tap;
		logic next_tap;
		logic dout_load;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic tap_done;
		logic pipe_empty;
	} dp_sts_t;

	function automatic logic signed [SampleW-1:0] sat16(
		input logic signed [AccW-1:0] acc);
		logic signed [AccW-1:0] r;
		begin
			r = (acc + AccW'(32768)) >>> 16;
			if (r > AccW'(32767))
				sat16 = 16'sd32767;
			else if (r < -AccW'(32768))
				sat16 = -16'sd32768;
			else
				sat16 = r[SampleW-1:0];
		end
	endfunction
endpackage
`default_nettype wire

### rtl/polyphase_fir_resampler_stereo_unit.sv
// Stereo polyphase FIR resampler.
// Input word (s_axis): tuser = mode; tdata = coef_index, coef_value, left_in,
// right_in. Output word (m_axis): tdata = left_out, right_out; tlast = last.
// A mode 0 word writes one coefficient and yields nothing. A mode 1 word
// pushes a stereo pair and yields zero to 64 output words, the final one
// marked with tlast.
// Each output word sums every U-th tap below T, T = tap_count, U = upsample_factor:
// one multiply-accumulate per cycle for each channel, fed by duplicate
// coefficient RAMs that read a tap and its neighbor. One input word is in work
// at a time; s_axis_tready is low until its last output word has been taken.
// Reset clears phase and registers to their reset values and the delay ring
// to zero (valid bits); coefficients are undefined until written.
// A stalled receiver holds the output word; the block waits.
// Configuration: cfg_we / cfg_index / cfg_data, one write per cycle, idle only.
`default_nettype none
module polyphase_fir_resampler_stereo_unit #(
	parameter int unsigned MAX_TAPS = 1024,
	parameter int unsigned DELAY_DEPTH = 64,
	parameter int unsigned MAX_PHASES = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [27:0] cfg_data,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [63:0] s_axis_tdata,  // coef_index, coef_value, left_in, right_in, pad
	input  wire logic        s_axis_tuser,  // mode
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata,  // left_out, right_out
	output logic             m_axis_tlast
);
	pfrs_pkg::dp_cmd_t cmd;
	pfrs_pkg::dp_sts_t sts;
	logic coef_we, interp;
	logic [pfrs_pkg::PhaseW-1:0] phase;
	logic [pfrs_pkg::UfW-1:0] uf;
	logic [pfrs_pkg::TapW-1:0] tap_count;
	logic signed [15:0] left_out, right_out;

	assign m_axis_tdata = {right_out, left_out};

	pfrs_ctrl #(.MaxPhases(MAX_PHASES)) u_ctrl (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_mode(s_axis_tuser),
		.out_ready(m_axis_tready), .out_valid(m_axis_tvalid), .out_last(m_axis_tlast),
		.cmd, .sts, .coef_we, .phase, .interp, .uf, .tap_count);

	pfrs_dp #(.MaxTaps(MAX_TAPS), .DelayDepth(DELAY_DEPTH)) u_dp (
		.clk, .arst_n, .cmd, .sts, .coef_we,
		.coef_index(s_axis_tdata[9:0]), .coef_value(s_axis_tdata[27:10]),
		.left_in(s_axis_tdata[43:28]), .right_in(s_axis_tdata[59:44]),
		.phase, .interp, .uf, .tap_count, .left_out, .right_out);
endmodule
`default_nettype wire

### rtl/pfrs_ram.sv
// Generic single-port-write, one-read RAM with registered read.
// No dependencies.
`default_nettype none
module pfrs_ram #(
	parameter int unsigned Width = 18,
	parameter int unsigned Depth = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic      [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

### rtl/pfrs_dp.sv
// Datapath: coefficient RAM, delay rings, tap walk, interpolation, MAC.
// Depends on pfrs_pkg and pfrs_ram.
`default_nettype none
module pfrs_dp #(
	parameter int unsigned MaxTaps = 1024,
	parameter int unsigned DelayDepth = 64
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire pfrs_pkg::dp_cmd_t             cmd,
	output pfrs_pkg::dp_sts_t                  sts,
	input  wire logic                          coef_we,
	input  wire logic [9:0]                    coef_index,
	input  wire logic signed [pfrs_pkg::CoefW-1:0]   coef_value,
	input  wire logic signed [pfrs_pkg::SampleW-1:0] left_in,
	input  wire logic signed [pfrs_pkg::SampleW-1:0] right_in,
	input  wire logic [pfrs_pkg::PhaseW-1:0]   phase,
	input  wire logic                          interp,
	input  wire logic [pfrs_pkg::UfW-1:0]      uf,
	input  wire logic [pfrs_pkg::TapW-1:0]     tap_count,
	output logic signed [pfrs_pkg::SampleW-1:0] left_out,
	output logic signed [pfrs_pkg::SampleW-1:0] right_out
);
	localparam int unsigned TaW = $clog2(MaxTaps);
	localparam int unsigned DaW = $clog2(DelayDepth);
	localparam int unsigned IdxW = ((TaW > pfrs_pkg::TapW) ? TaW : pfrs_pkg::TapW) + 2;

	logic [IdxW-1:0] tap_q;
	logic [DaW-1:0] d_q, pos_q;
	logic [DelayDepth-1:0] lvalid_q;
	logic [pfrs_pkg::CoefW-1:0] c0_rd, c1_rd;
	logic [pfrs_pkg::SampleW-1:0] l_rd, r_rd;
	logic ok0_s1, ok1_s1, v_s1, sv_s1;
	logic signed [pfrs_pkg::CoefW-1:0] tap_s2;
	logic signed [pfrs_pkg::SampleW-1:0] l_s2, r_s2;
	logic v_s2, v_s3;
	logic signed [pfrs_pkg::CoefW+pfrs_pkg::SampleW:0] pl_s3, pr_s3;
	logic signed [pfrs_pkg::AccW-1:0] accl_q, accr_q;
	logic [IdxW-1:0] tap_next;
	logic in_range0, in_range1;
	logic [DaW-1:0] pos_dec;
	logic [DaW-1:0] ring_waddr;
	logic signed [pfrs_pkg::CoefW:0] diff;
	logic signed [pfrs_pkg::CoefW+17:0] prod;
	logic signed [pfrs_pkg::CoefW:0] corr;
	logic signed [pfrs_pkg::CoefW-1:0] c0s, c1s;
	logic coef_wr;

	assign in_range0 = (tap_q < IdxW'(tap_count)) && (tap_q < IdxW'(MaxTaps));
	assign in_range1 = (tap_q + 1'b1 < IdxW'(tap_count)) && (tap_q + 1'b1 < IdxW'(MaxTaps));
	assign tap_next = tap_q + IdxW'(uf);
	assign pos_dec = (pos_q == '0) ? DaW'(DelayDepth - 1) : pos_q - 1'b1;
	assign ring_waddr = cmd.push ? pos_dec : d_q;
	assign sts.tap_done = !in_range0;
	assign sts.pipe_empty = !v_s1 && !v_s2 && !v_s3;
	// drop coefficient writes past the kernel store
	assign coef_wr = coef_we && (32'(coef_index) < MaxTaps);

	// two coefficient RAMs hold the same data so tap and neighbor read together
	pfrs_ram #(.Width(pfrs_pkg::CoefW), .Depth(MaxTaps)) u_coef0 (
		.clk, .we(coef_wr), .waddr(TaW'(coef_index)), .wdata(coef_value),
		.raddr(tap_q[TaW-1:0]), .rdata(c0_rd));
	pfrs_ram #(.Width(pfrs_pkg::CoefW), .Depth(MaxTaps)) u_coef1 (
		.clk, .we(coef_wr), .waddr(TaW'(coef_index)), .wdata(coef_value),
		.raddr(TaW'(tap_q + 1'b1)), .rdata(c1_rd));
	pfrs_ram #(.Width(pfrs_pkg::SampleW), .Depth(DelayDepth)) u_left (
		.clk, .we(cmd.push), .waddr(ring_waddr), .wdata(left_in),
		.raddr(d_q), .rdata(l_rd));
	pfrs_ram #(.Width(pfrs_pkg::SampleW), .Depth(DelayDepth)) u_right (
		.clk, .we(cmd.push), .waddr(ring_waddr), .wdata(right_in),
		.raddr(d_q), .rdata(r_rd));

	// tap walk and ring pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_q <= '0;
			d_q <= '0;
			pos_q <= '0;
			lvalid_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (cmd.push) begin
				pos_q <= pos_dec;
				lvalid_q[pos_dec] <= 1'b1;
			end
			if (cmd.set_tap) begin
				tap_q <= IdxW'(phase[pfrs_pkg::PhaseW-1:16]);
				d_q <= pos_q;
			end else if (cmd.next_tap) begin
				tap_q <= tap_next;
				d_q <= (d_q == DaW'(DelayDepth - 1)) ? '0 : d_q + 1'b1;
			end
			v_s1 <= cmd.mac_en;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// stage 1 flags
	always_ff @(posedge clk) begin
		ok0_s1 <= in_range0;
		ok1_s1 <= in_range1;
		sv_s1 <= lvalid_q[d_q];
	end

	// stage 2: interpolate tap
	assign c0s = ok0_s1 ? c0_rd : '0;
	assign c1s = ok1_s1 ? c1_rd : '0;
	assign diff = c1s - c0s;
	assign prod = diff * $signed({1'b0, phase[15:0]}) + 32768;
	assign corr = prod[pfrs_pkg::CoefW+16:16];
	always_ff @(posedge clk) begin
		tap_s2 <= interp ? pfrs_pkg::CoefW'(c0s + corr) : c0s;
		l_s2 <= sv_s1 ? l_rd : '0;
		r_s2 <= sv_s1 ? r_rd : '0;
	end

	// stage 3: products
	always_ff @(posedge clk) begin
		pl_s3 <= tap_s2 * l_s2;
		pr_s3 <= tap_s2 * r_s2;
	end

	// accumulate and load output
	always_ff @(posedge clk) begin
		if (cmd.clear_acc) begin
			accl_q <= '0;
			accr_q <= '0;
		end else if (v_s3) begin
			accl_q <= accl_q + pfrs_pkg::AccW'(pl_s3);
			accr_q <= accr_q + pfrs_pkg::AccW'(pr_s3);
		end
		if (cmd.dout_load) begin
			left_out <= pfrs_pkg::sat16(accl_q);
			right_out <= pfrs_pkg::sat16(accr_q);
		end
	end
endmodule
`default_nettype wire

### rtl/pfrs_ctrl.sv
// Controller: registers, phase accumulator, handshakes, sequencing.
// Depends on pfrs_pkg.
`default_nettype none
module pfrs_ctrl #(
	parameter int unsigned MaxPhases = 64
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_we,
	input  wire logic [1:0]                  cfg_index,
	input  wire logic [27:0]                 cfg_data,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic                        in_mode,
	input  wire logic                        out_ready,
	output logic                             out_valid,
	output logic                             out_last,
	output pfrs_pkg::dp_cmd_t                cmd,
	input  wire pfrs_pkg::dp_sts_t           sts,
	output logic                             coef_we,
	output logic [pfrs_pkg::PhaseW-1:0]      phase,
	output logic                             interp,
	output logic [pfrs_pkg::UfW-1:0]         uf,
	output logic [pfrs_pkg::TapW-1:0]        tap_count
);
	typedef enum logic [2:0] {ST_IDLE, ST_CHECK, ST_START, ST_RUN, ST_DRAIN, ST_OUT}
		state_t;
	state_t state_q;
	logic [pfrs_pkg::PhaseW-1:0] phase_q;
	logic [pfrs_pkg::IncW-1:0] inc_q;
	logic [pfrs_pkg::UfW-1:0] uf_q;
	logic [pfrs_pkg::TapW-1:0] taps_q;
	logic [6:0] n_q;
	logic [pfrs_pkg::PhaseW-1:0] limit;
	logic [pfrs_pkg::PhaseW-1:0] phase_nx;
	logic [pfrs_pkg::UfW-1:0] uf_wr;
	logic accept, last_nx;

	assign limit = {uf_q, 16'd0};
	assign phase = phase_q;
	assign interp = inc_q[15:0] != '0;
	assign uf = uf_q;
	assign tap_count = taps_q;
	assign in_ready = (state_q == ST_IDLE);
	assign accept = in_valid && in_ready;
	assign coef_we = accept && !in_mode;
	assign phase_nx = phase_q + pfrs_pkg::PhaseW'(inc_q);
	assign last_nx = !(phase_nx < limit) || (n_q == 7'(pfrs_pkg::ResultCap - 1));
	assign uf_wr = (32'(cfg_data[6:0]) > MaxPhases)
		? pfrs_pkg::UfW'(MaxPhases) : cfg_data[6:0];

	// datapath commands
	always_comb begin
		cmd = '0;
		cmd.push = accept && in_mode;
		cmd.set_tap = (state_q == ST_START);
		cmd.clear_acc = (state_q == ST_START);
		cmd.mac_en = (state_q == ST_RUN) && !sts.tap_done;
		cmd.next_tap = cmd.mac_en;
		cmd.dout_load = (state_q == ST_DRAIN) && sts.pipe_empty;
	end

	// state, registers and phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= pfrs_pkg::PhaseW'(1) << 16;
			inc_q <= pfrs_pkg::IncW'(65536);
			uf_q <= pfrs_pkg::UfW'(1);
			taps_q <= pfrs_pkg::TapW'(1);
			n_q <= '0;
			out_valid <= 1'b0;
			out_last <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					pfrs_pkg::RegUpsample: begin
						uf_q <= uf_wr;
						phase_q <= {uf_wr, 16'd0};
					end
					pfrs_pkg::RegIncrement: inc_q <= cfg_data;
					pfrs_pkg::RegTapCount: taps_q <= cfg_data[pfrs_pkg::TapW-1:0];
					default: ;
				endcase
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && in_mode) begin
						phase_q <= (phase_q >= limit) ? phase_q - limit : '0;
						n_q <= '0;
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: state_q <= (phase_q < limit) ? ST_START : ST_IDLE;
				ST_START: state_q <= ST_RUN;
				ST_RUN: if (sts.tap_done) state_q <= ST_DRAIN;
				ST_DRAIN: begin
					if (sts.pipe_empty) begin
						out_valid <= 1'b1;
						out_last <= last_nx;
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_ready) begin
						out_valid <= 1'b0;
						phase_q <= phase_nx;
						n_q <= n_q + 1'b1;
						state_q <= out_last ? ST_IDLE : ST_START;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

### rtl/pfrs_checker.sv
// Port-level checker for the resampler, bound to the top level.
// No package dependencies.
`default_nettype none
module pfrs_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	input wire logic s_axis_tready,
	input wire logic m_axis_tvalid,
	input wire logic m_axis_tready,
	input wire logic m_axis_tlast
);
	// no output word while a new input is being taken
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_axis_tready && m_axis_tvalid)) else $error("in/out overlap");
	// output word holds under stall
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid) else $error("drop");
	// last word frees the input
	a_free: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready)
		else $error("not freed");
endmodule

bind polyphase_fir_resampler_stereo_unit pfrs_checker u_pfrs_checker (
	.clk, .arst_n, .s_axis_tvalid, .s_axis_tready,
	.m_axis_tvalid, .m_axis_tready, .m_axis_tlast);
`default_nettype wire

### sim/testbench.sv
// Testbench for polyphase_fir_resampler_stereo_unit: random and directed stereo words,
// checked against a bit-true resampler predictor held in a small scoreboard class.
// Depends on rtl/pfrs_pkg.sv and rtl/polyphase_fir_resampler_stereo_unit.sv.
`timescale 1ns / 100ps
module testbench;
	localparam int unsigned NumTaps = 1024;
	localparam int unsigned FillTaps = 72;
	localparam int unsigned RingDepth = 64;
	localparam int unsigned PhaseMax = 64;
	localparam logic [1:0] RegUnused = 2'd3;
	localparam logic ModeLoad = 1'b0;
	localparam logic ModePush = 1'b1;
	localparam int unsigned SettleCycles = 1500;

	typedef struct {
		logic signed [pfrs_pkg::SampleW-1:0] left;
		logic signed [pfrs_pkg::SampleW-1:0] right;
		logic last;
	} out_pair_t;

	class resampler_scoreboard;
		logic signed [pfrs_pkg::CoefW-1:0] coefs [NumTaps];
		logic signed [pfrs_pkg::SampleW-1:0] left_hist [RingDepth];
		logic signed [pfrs_pkg::SampleW-1:0] right_hist [RingDepth];
		int unsigned newest;
		int unsigned phase;
		int unsigned factor;
		int unsigned incr;
		int unsigned taps;
		out_pair_t expected_pairs [$];
		int errors;

		function new();
			foreach (coefs[i]) coefs[i] = '0;
			foreach (left_hist[i]) begin
				left_hist[i] = '0;
				right_hist[i] = '0;
			end
			newest = 0;
			factor = 1;
			incr = 32'h10000;
			taps = 1;
			phase = factor << 16;
			errors = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [27:0] value);
			if (idx == pfrs_pkg::RegUpsample) begin
				factor = value[6:0];
				if (factor > PhaseMax) factor = PhaseMax;
				phase = factor << 16;
			end else if (idx == pfrs_pkg::RegIncrement) begin
				incr = value;
			end else if (idx == pfrs_pkg::RegTapCount) begin
				taps = value[10:0];
			end
		endfunction

		function longint tap_at(int unsigned i);
			if (i >= taps || i >= NumTaps) return 0;
			return longint'(coefs[i]);
		endfunction

		function logic signed [pfrs_pkg::SampleW-1:0] round_sat(longint acc);
			longint r;
			r = (acc + 32768) >>> 16;
			if (r > 32767) r = 32767;
			if (r < -32768) r = -32768;
			return r[pfrs_pkg::SampleW-1:0];
		endfunction

		// one filtered output pair at the current phase
		function out_pair_t filter_pair();
			out_pair_t p;
			longint accl, accr, c, diff, frac;
			int unsigned d, i;
			bit interp;
			interp = (incr[15:0] != 0);
			frac = phase & 32'hFFFF;
			accl = 0;
			accr = 0;
			d = newest;
			for (i = phase >> 16; i < taps; i += factor) begin
				c = tap_at(i);
				if (interp) begin
					diff = tap_at(i + 1) - c;
					c += (diff * frac + 32768) >>> 16;
				end
				accl += c * longint'(left_hist[d]);
				accr += c * longint'(right_hist[d]);
				d = (d + 1 >= RingDepth) ? 0 : d + 1;
			end
			p.left = round_sat(accl);
			p.right = round_sat(accr);
			p.last = 1'b0;
			return p;
		endfunction

		function void note_word(logic mode, logic [9:0] idx, logic signed [17:0] value,
				logic signed [15:0] l, logic signed [15:0] r);
			int unsigned lim, n;
			out_pair_t p;
			if (mode == ModeLoad) begin
				coefs[idx] = value;
				return;
			end
			newest = (newest == 0) ? RingDepth - 1 : newest - 1;
			left_hist[newest] = l;
			right_hist[newest] = r;
			lim = factor << 16;
			phase = (phase >= lim) ? phase - lim : 0;
			n = 0;
			while (phase < lim && n < pfrs_pkg::ResultCap) begin
				p = filter_pair();
				expected_pairs.push_back(p);
				phase = (phase + incr) & 32'h1FFFFFFF;
				n++;
			end
			if (n > 0) expected_pairs[$].last = 1'b1;
		endfunction

		task report(string what);
			$display("%0t: %s", $time, what);
			errors++;
		endtask

		task check_word(logic signed [15:0] l, logic signed [15:0] r, logic last);
			out_pair_t e;
			if (expected_pairs.size() == 0) begin
				report($sformatf("unexpected word L=%0d R=%0d last=%0b", l, r, last));
				return;
			end
			e = expected_pairs.pop_front();
			if (l !== e.left) report($sformatf("left %0d, want %0d", l, e.left));
			if (r !== e.right) report($sformatf("right %0d, want %0d", r, e.right));
			if (last !== e.last) report($sformatf("last %0b, want %0b", last, e.last));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [27:0] cfg_data = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [63:0] s_axis_tdata = '0;  // coef_index, coef_value, left_in, right_in, pad
	logic s_axis_tuser = 1'b0;       // mode
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;       // left_out, right_out
	logic m_axis_tlast;

	resampler_scoreboard sb = new();
	int stall_hold = 0;
	int burst_left = 0;

	polyphase_fir_resampler_stereo_unit uut (.*);

	always #1 clk = ~clk;

	initial begin
		#40_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// receiver: long hold-off when asked, else one of four ready patterns, redrawn at random at regular intervals
	always @(negedge clk) begin
		static int unsigned tick = 0;
		static int unsigned style = 0;
		tick++;
		if (tick % 256 == 0) style = $urandom_range(0, 3);
		if (stall_hold > 0) begin
			m_axis_tready <= 1'b0;
			stall_hold--;
		end else begin
			case (style)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= ($urandom_range(0, 1) == 1);
				2: m_axis_tready <= ($urandom_range(0, 3) == 0);
				default: m_axis_tready <= ($urandom_range(0, 9) != 0);
			endcase
		end
	end

	// check each accepted output word
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			sb.check_word(m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tlast);
	end

	task send_word(logic mode, logic [9:0] idx, logic [17:0] value,
			logic [15:0] l, logic [15:0] r);
		@(negedge clk);
		s_axis_tvalid = 1'b1;
		s_axis_tuser = mode;
		s_axis_tdata = {4'b0, r, l, value, idx};
		do @(posedge clk); while (!s_axis_tready);
		sb.note_word(mode, idx, value, l, r);
	endtask

	// drop valid between bursts
	task burst_gap();
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		repeat ($urandom_range(0, 20)) @(negedge clk);
		burst_left = $urandom_range(0, 12);
	endtask

	task drain();
		@(negedge clk);
		s_axis_tvalid = 1'b0;
		while (sb.expected_pairs.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task write_reg(logic [1:0] idx, logic [27:0] value);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = value;
		@(negedge clk);
		cfg_we = 1'b0;
		sb.set_reg(idx, value);
	endtask

	task random_items(int count);
		for (int k = 0; k < count; k++) begin
			burst_gap();
			if ($urandom_range(0, 6) == 0)
				send_word(ModeLoad, $urandom_range(0, NumTaps - 1), $urandom, '0, '0);
			else
				send_word(ModePush, $urandom, $urandom, $urandom, $urandom);
		end
	endtask

	task new_setting(logic [27:0] uf, logic [27:0] inc, logic [27:0] tc, int count);
		drain();
		write_reg(pfrs_pkg::RegIncrement, inc);
		write_reg(pfrs_pkg::RegTapCount, tc);
		write_reg(pfrs_pkg::RegUpsample, uf);
		random_items(count);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// fill the kernel up to the largest tap count used below
		for (int i = 0; i < FillTaps; i++)
			send_word(ModeLoad, i, (i % 97 == 0) ? 18'h1FFFF : $urandom, '0, '0);

		// directed: sample and coefficient extremes with one tap
		send_word(ModePush, '0, '0, 16'h7FFF, 16'h8000);
		send_word(ModeLoad, 10'd0, 18'h1FFFF, '0, '0);
		send_word(ModePush, 10'h3FF, '0, 16'h7FFF, 16'h8000);
		send_word(ModePush, '0, '0, 16'h8000, 16'h7FFF);
		send_word(ModeLoad, 10'd0, 18'h20000, '0, '0);
		send_word(ModePush, '0, '0, 16'h8000, 16'h7FFF);
		send_word(ModePush, '0, 18'h3FFFF, 16'hFFFF, 16'h0001);
		send_word(ModeLoad, 10'h3FF, 18'h2AAAA, '0, '0);
		send_word(ModeLoad, 10'd1, 18'h15555, '0, '0);
		send_word(ModePush, '0, '0, 16'h0000, 16'hFFFF);
		// unknown register index leaves everything as it is
		drain();
		write_reg(RegUnused, 28'hFFFFFFF);
		send_word(ModePush, '0, '0, 16'h1234, 16'hEDCB);

		// settings sweep, with a long receiver hold-off in the first one
		drain();
		write_reg(pfrs_pkg::RegTapCount, 28'd32);
		write_reg(pfrs_pkg::RegIncrement, 28'd43690);
		write_reg(pfrs_pkg::RegUpsample, 28'd2);
		stall_hold = 3000;
		random_items(10);
		new_setting(28'd4, 28'h0038000, 28'd48, 6);
		new_setting(28'd64, 28'h0010000, 28'd72, 4);
		new_setting(28'd127, 28'd0, 28'd16, 3);
		new_setting(28'd0, 28'h0010000, 28'd8, 3);
		new_setting(28'd1, 28'hFFFFFFF, 28'd72, 3);
		new_setting(28'd3, 28'h0010001, 28'd72, 3);
		new_setting(28'd5, 28'h0004000, 28'd1, 6);
		new_setting(28'd2, 28'h0018000, 28'd70, 6);
		new_setting(28'd1, 28'h0010000, 28'd72, 4);

		drain();
		if (sb.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
